// ===== hw/rtl/rc4_pkg.sv =====
// rc4_pkg: shared types and constants for the rc4 stream cipher core
// used by the channel interfaces, the engine and the top level
`default_nettype none

package rc4_pkg;

	localparam int KEY_BYTES  = 16;
	localparam int KEY_W      = KEY_BYTES * 8;
	localparam int KIDX_W     = $clog2(KEY_BYTES);
	localparam int LEN_W      = 5;
	localparam int TBL_AW     = 8;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [TBL_AW-1:0] tbl_addr_t;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

	localparam logic [LEN_W-1:0] KEY_LEN_RESET = LEN_W'(KEY_BYTES);
	localparam tbl_addr_t TBL_LAST = {TBL_AW{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_KS_RD_I,
		ST_KS_RD_J,
		ST_KS_WR_I,
		ST_KS_WR_J,
		ST_PG_RD_I,
		ST_PG_RD_J,
		ST_PG_WR_I,
		ST_PG_WR_J,
		ST_PG_OUT
	} rc4_state_t;

	// key material as seen by the engine
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [KIDX_W-1:0] len_m1;
	} rc4_key_t;

	typedef struct packed {
		logic start;
		logic schedule;
		logic out_free;
	} rc4_ctl_t;

	typedef struct packed {
		logic  busy;
		logic  ks_valid;
		byte_t ks;
	} rc4_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rc4_ifs.sv =====
// rc4_ifs: valid/ready channel interfaces for input items, result items
// and configuration writes; depends on rc4_pkg
`default_nettype none

interface rc4_in_if;
	import rc4_pkg::*;
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  restart;
	logic  last_in;
	modport source (output valid, data_byte, restart, last_in, input ready);
	modport sink   (input valid, data_byte, restart, last_in, output ready);
endinterface

interface rc4_out_if;
	import rc4_pkg::*;
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  last_out;
	modport source (output valid, out_byte, last_out, input ready);
	modport sink   (input valid, out_byte, last_out, output ready);
endinterface

interface rc4_cfg_if;
	import rc4_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rc4_stream_cipher_core.sv =====
// rc4_stream_cipher_core: top level with configuration registers, item
// capture and output register; depends on rc4_pkg, rc4_ifs, rc4_engine
//
//  channel  dir  payload                      accepted when
//  din      in   data_byte, restart, last_in  din.valid && din.ready
//  dout     out  out_byte, last_out           dout.valid && dout.ready
//  cfg      in   index, data                  cfg.valid && cfg.ready
//
// one item runs the steps read i, read j, write i, write j (with the output
// read) and output, set by the single read and single write port of the
// permutation memory
// a restart (and the first item after reset) adds an identity fill of the
// 256 entries, then 256 schedule steps of two reads and two writes each
// din.ready is low while an item is at work; a result waiting in dout
// holds the next one in its last step; cfg.ready is always high
`default_nettype none

module rc4_stream_cipher_core (
	input  wire logic clk,
	input  wire logic arst_n,
	rc4_in_if.sink    din,
	rc4_out_if.source dout,
	rc4_cfg_if.sink   cfg
);
	import rc4_pkg::*;

	logic [CFG_DATA_W-1:0] key_low_q, key_high_q;
	logic [LEN_W-1:0]      key_len_q;

	byte_t data_q;
	logic  last_q;

	logic  out_valid_q;
	byte_t out_byte_q;
	logic  last_out_q;

	rc4_key_t key_cfg;
	rc4_ctl_t ctl;
	rc4_sts_t sts;
	logic     in_fire;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			key_len_q  <= KEY_LEN_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_KEY_LOW:  key_low_q  <= cfg.data;
				CFG_KEY_HIGH: key_high_q <= cfg.data;
				CFG_KEY_LEN:  key_len_q  <= cfg.data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// clamp key length to 1..KEY_BYTES
	always_comb begin
		key_cfg.key = {key_high_q, key_low_q};
		priority if (key_len_q == '0) begin
			key_cfg.len_m1 = '0;
		end else if (key_len_q > LEN_W'(KEY_BYTES)) begin
			key_cfg.len_m1 = KIDX_W'(KEY_BYTES - 1);
		end else begin
			key_cfg.len_m1 = KIDX_W'(key_len_q - 1'b1);
		end
	end

	assign din.ready    = !sts.busy;
	assign in_fire      = din.valid && din.ready;
	assign ctl.start    = in_fire;
	assign ctl.schedule = din.restart;
	assign ctl.out_free = !out_valid_q || dout.ready;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_q <= din.data_byte;
			last_q <= din.last_in;
		end
	end

	rc4_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.key_cfg (key_cfg),
		.ctl     (ctl),
		.sts     (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sts.ks_valid) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.ks_valid) begin
			out_byte_q <= data_q ^ sts.ks;
			last_out_q <= last_q;
		end
	end

	assign dout.valid    = out_valid_q;
	assign dout.out_byte = out_byte_q;
	assign dout.last_out = last_out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rc4_sbox_ram.sv =====
// rc4_sbox_ram: generic single write, single read memory with registered
// read data; no dependencies
`default_nettype none

module rc4_sbox_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rc4_engine.sv =====
// rc4_engine: sequencer for the key schedule and keystream generation,
// driving the permutation memory; depends on rc4_pkg, rc4_sbox_ram
`default_nettype none

module rc4_engine (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rc4_pkg::rc4_key_t key_cfg,
	input  wire rc4_pkg::rc4_ctl_t ctl,
	output rc4_pkg::rc4_sts_t      sts
);
	import rc4_pkg::*;

	rc4_state_t        state_q, state_d;
	tbl_addr_t         n_q;
	logic [KIDX_W-1:0] kidx_q;
	byte_t             i_q, j_q;
	byte_t             si_q, sj_q;
	logic              hit_q;
	logic              keyed_q;

	logic      ram_we, ram_re;
	tbl_addr_t ram_waddr, ram_raddr;
	byte_t     ram_wdata, ram_rdata;
	logic      ks_valid;

	byte_t key_byte;
	byte_t j_ks, j_pg, k_addr;

	rc4_sbox_ram #(
		.ADDR_W(TBL_AW),
		.DATA_W(BYTE_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign key_byte = key_cfg.key[{kidx_q, 3'b000} +: BYTE_W];
	assign j_ks     = j_q + ram_rdata + key_byte;
	assign j_pg     = j_q + ram_rdata;
	assign k_addr   = si_q + sj_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		ks_valid  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (ctl.start) begin
					state_d = (ctl.schedule || !keyed_q) ? ST_INIT : ST_PG_RD_I;
				end
			end
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = n_q;
				ram_wdata = n_q;
				if (n_q == TBL_LAST) begin
					state_d = ST_KS_RD_I;
				end
			end
			ST_KS_RD_I: begin
				ram_re    = 1'b1;
				ram_raddr = n_q;
				state_d   = ST_KS_RD_J;
			end
			ST_KS_RD_J: begin
				ram_re    = 1'b1;
				ram_raddr = j_ks;
				state_d   = ST_KS_WR_I;
			end
			ST_KS_WR_I: begin
				ram_we    = 1'b1;
				ram_waddr = n_q;
				ram_wdata = ram_rdata;
				state_d   = ST_KS_WR_J;
			end
			ST_KS_WR_J: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = si_q;
				state_d   = (n_q == TBL_LAST) ? ST_PG_RD_I : ST_KS_RD_I;
			end
			ST_PG_RD_I: begin
				ram_re    = 1'b1;
				ram_raddr = i_q + 8'd1;
				state_d   = ST_PG_RD_J;
			end
			ST_PG_RD_J: begin
				ram_re    = 1'b1;
				ram_raddr = j_pg;
				state_d   = ST_PG_WR_I;
			end
			ST_PG_WR_I: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
				ram_wdata = ram_rdata;
				state_d   = ST_PG_WR_J;
			end
			ST_PG_WR_J: begin
				// output read overlaps the second swap write, see hit_q
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = si_q;
				ram_re    = 1'b1;
				ram_raddr = k_addr;
				state_d   = ST_PG_OUT;
			end
			ST_PG_OUT: begin
				if (ctl.out_free) begin
					ks_valid = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign sts.ks_valid = ks_valid;
	assign sts.busy     = (state_q != ST_IDLE);
	assign sts.ks       = hit_q ? si_q : ram_rdata;

	// indices and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			kidx_q  <= '0;
			i_q     <= '0;
			j_q     <= '0;
			keyed_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.start && (ctl.schedule || !keyed_q)) begin
						n_q    <= '0;
						kidx_q <= '0;
						j_q    <= '0;
					end
				end
				ST_INIT: begin
					n_q <= n_q + 1'b1;
				end
				ST_KS_RD_J: begin
					j_q <= j_ks;
				end
				ST_KS_WR_J: begin
					n_q    <= n_q + 1'b1;
					kidx_q <= (kidx_q == key_cfg.len_m1) ? '0 : kidx_q + 1'b1;
					if (n_q == TBL_LAST) begin
						i_q     <= '0;
						j_q     <= '0;
						keyed_q <= 1'b1;
					end
				end
				ST_PG_RD_I: begin
					i_q <= i_q + 8'd1;
				end
				ST_PG_RD_J: begin
					j_q <= j_pg;
				end
				default: begin
				end
			endcase
		end
	end

	// swap operands
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_KS_RD_J, ST_PG_RD_J: begin
				si_q <= ram_rdata;
			end
			ST_PG_WR_I: begin
				sj_q <= ram_rdata;
			end
			ST_PG_WR_J: begin
				hit_q <= (k_addr == j_q);
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> state_q == ST_IDLE)
		else $error("item started while engine busy");

	a_ks_free: assert property (@(posedge clk) disable iff (!arst_n)
		sts.ks_valid |-> ctl.out_free)
		else $error("keystream byte issued with output register full");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_PG_OUT) |-> !ram_we)
		else $error("table written outside a schedule or swap step");

	a_out_follows_swap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PG_WR_J |=> state_q == ST_PG_OUT)
		else $error("swap not followed by output step");

	a_keyed_after_sched: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(keyed_q) |-> $past(state_q) == ST_KS_WR_J && $past(n_q) == TBL_LAST)
		else $error("keyed set without a finished key schedule");
`endif

endmodule

`default_nettype wire
